// ===== src/rebq_pkg.sv =====
// package: shared types, register indexes and constants of the rotary encoder and button qualifier
package rebq_pkg;

    typedef struct packed {
        logic clk_level;
        logic dt_level;
        logic button_level;
        logic ack_cw;
        logic ack_ccw;
    } in_t;

    typedef struct packed {
        logic       cw_pending;
        logic       ccw_pending;
        logic [1:0] press_class;
    } out_t;

    typedef struct packed {
        logic [15:0] full;
        logic [15:0] half;
        logic [15:0] min;
    } thresh_t;

    typedef enum logic [2:0] {
        REG_DIRECTION_SWAP   = 3'd0,
        REG_FILTER_ROOF      = 3'd1,
        REG_FILTER_THRESHOLD = 3'd2,
        REG_PRESCALE_RELOAD  = 3'd3,
        REG_THRESH_FULL      = 3'd4,
        REG_THRESH_HALF      = 3'd5,
        REG_THRESH_MIN       = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_MIN  = 2'd1,
        CLASS_HALF = 2'd2,
        CLASS_FULL = 2'd3
    } press_class_t;

    localparam int CFG_DATA_W = 16;

    localparam logic        RST_DIRECTION_SWAP   = 1'b0;
    localparam logic [7:0]  RST_FILTER_ROOF      = 8'd10;
    localparam logic [7:0]  RST_FILTER_THRESHOLD = 8'd3;
    localparam logic [7:0]  RST_PRESCALE_RELOAD  = 8'd5;
    localparam logic [15:0] RST_THRESH_FULL      = 16'd1000;
    localparam logic [15:0] RST_THRESH_HALF      = 16'd100;
    localparam logic [15:0] RST_THRESH_MIN       = 16'd5;

    localparam int DECAY_BIG_ABOVE = 50;
    localparam int DECAY_BIG       = 50;
    localparam int DECAY_MID_ABOVE = 10;
    localparam int DECAY_MID       = 5;

    // saturating up/down integrator, holds above the roof on a high pin
    function automatic logic [7:0] integrate(input logic [7:0] acc, input logic pin,
                                             input logic [7:0] roof);
        logic [7:0] res;
        res = acc;
        if (pin) begin
            if (acc < roof) begin
                res = acc + 8'd1;
            end
        end else if (acc != 8'd0) begin
            res = acc - 8'd1;
        end
        return res;
    endfunction

endpackage

// ===== src/rebq_hold.sv =====
// button hold counter with banded decay and press classification
module rebq_hold #(
    parameter int HOLD_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   update,
    input  logic                   pressed,
    input  rebq_pkg::thresh_t      thresh,
    output rebq_pkg::press_class_t press_class_next
);

    localparam int CMP_W = (HOLD_WIDTH > 16) ? HOLD_WIDTH : 16;

    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX  = {HOLD_WIDTH{1'b1}};
    localparam logic [HOLD_WIDTH-1:0] BIG_ABOVE = HOLD_WIDTH'(rebq_pkg::DECAY_BIG_ABOVE);
    localparam logic [HOLD_WIDTH-1:0] BIG_STEP  = HOLD_WIDTH'(rebq_pkg::DECAY_BIG);
    localparam logic [HOLD_WIDTH-1:0] MID_ABOVE = HOLD_WIDTH'(rebq_pkg::DECAY_MID_ABOVE);
    localparam logic [HOLD_WIDTH-1:0] MID_STEP  = HOLD_WIDTH'(rebq_pkg::DECAY_MID);
    localparam logic [HOLD_WIDTH-1:0] ONE       = HOLD_WIDTH'(1);

    logic [HOLD_WIDTH-1:0] hold_reg;
    logic [HOLD_WIDTH-1:0] hold_calc;
    logic [HOLD_WIDTH-1:0] hold_next;
    logic [CMP_W-1:0]      hold_ext;

    always_comb begin
        hold_calc = hold_reg;
        priority if (pressed) begin
            if (hold_reg != HOLD_MAX) begin
                hold_calc = hold_reg + ONE;
            end
        end else if (hold_reg > BIG_ABOVE) begin
            hold_calc = hold_reg - BIG_STEP;
        end else if (hold_reg > MID_ABOVE) begin
            hold_calc = hold_reg - MID_STEP;
        end else if (hold_reg != '0) begin
            hold_calc = hold_reg - ONE;
        end
    end

    assign hold_next = update ? hold_calc : hold_reg;
    assign hold_ext  = CMP_W'(hold_next);

    always_comb begin
        priority if (hold_ext > CMP_W'(thresh.full)) begin
            press_class_next = rebq_pkg::CLASS_FULL;
        end else if (hold_ext > CMP_W'(thresh.half)) begin
            press_class_next = rebq_pkg::CLASS_HALF;
        end else if (hold_ext > CMP_W'(thresh.min)) begin
            press_class_next = rebq_pkg::CLASS_MIN;
        end else begin
            press_class_next = rebq_pkg::CLASS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else begin
            hold_reg <= hold_next;
        end
    end

endmodule

// ===== src/rotary_encoder_and_button_qualifier.sv =====
// top level: encoder filtering, step flags, prescaler, result register and config registers
// the result of an accepted input transaction is registered into m_valid/m_data
// throughput: 1 transaction per cycle unless m_ready stalls the single result register
// s_ready stays high while the result register is empty or being taken this cycle
// reset (aresetn low, synchronous): filter state, flags, prescaler and hold count clear,
// config registers return to their defaults, no result is pending
module rotary_encoder_and_button_qualifier #(
    parameter int HOLD_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rebq_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rebq_pkg::out_t                  m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  rebq_pkg::cfg_index_t            cfg_addr,
    input  logic [rebq_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic              direction_swap_reg;
    logic [7:0]        filter_roof_reg;
    logic [7:0]        filter_threshold_reg;
    logic [7:0]        prescale_reload_reg;
    rebq_pkg::thresh_t thresh_reg;

    logic [7:0]        clk_int_reg,  clk_int_next;
    logic [7:0]        dt_int_reg,   dt_int_next;
    logic              last_qclk_reg;
    logic              cw_flag_reg,  cw_flag_next;
    logic              ccw_flag_reg, ccw_flag_next;
    logic [7:0]        prescale_cnt_reg, prescale_cnt_next;

    logic              m_valid_reg;
    rebq_pkg::out_t    m_data_reg;

    logic                   s_fire;
    logic                   qclk;
    logic                   qdt;
    logic                   edge_fire;
    logic                   clockwise;
    logic                   hold_update;
    rebq_pkg::press_class_t press_class_next;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_swap_reg   <= rebq_pkg::RST_DIRECTION_SWAP;
            filter_roof_reg      <= rebq_pkg::RST_FILTER_ROOF;
            filter_threshold_reg <= rebq_pkg::RST_FILTER_THRESHOLD;
            prescale_reload_reg  <= rebq_pkg::RST_PRESCALE_RELOAD;
            thresh_reg.full      <= rebq_pkg::RST_THRESH_FULL;
            thresh_reg.half      <= rebq_pkg::RST_THRESH_HALF;
            thresh_reg.min       <= rebq_pkg::RST_THRESH_MIN;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                rebq_pkg::REG_DIRECTION_SWAP:   direction_swap_reg   <= cfg_data[0];
                rebq_pkg::REG_FILTER_ROOF:      filter_roof_reg      <= cfg_data[7:0];
                rebq_pkg::REG_FILTER_THRESHOLD: filter_threshold_reg <= cfg_data[7:0];
                rebq_pkg::REG_PRESCALE_RELOAD:  prescale_reload_reg  <= cfg_data[7:0];
                rebq_pkg::REG_THRESH_FULL:      thresh_reg.full      <= cfg_data[15:0];
                rebq_pkg::REG_THRESH_HALF:      thresh_reg.half      <= cfg_data[15:0];
                rebq_pkg::REG_THRESH_MIN:       thresh_reg.min       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // encoder filtering and step detection
    always_comb begin
        clk_int_next = rebq_pkg::integrate(clk_int_reg, s_data.clk_level, filter_roof_reg);
        dt_int_next  = rebq_pkg::integrate(dt_int_reg, s_data.dt_level, filter_roof_reg);
        qclk         = clk_int_next > filter_threshold_reg;
        qdt          = dt_int_next > filter_threshold_reg;
        edge_fire    = !last_qclk_reg && qclk;
        clockwise    = qdt ^ direction_swap_reg;
        // ack clears first, a new edge in the same transaction wins
        cw_flag_next  = (cw_flag_reg && !s_data.ack_cw) || (edge_fire && clockwise);
        ccw_flag_next = (ccw_flag_reg && !s_data.ack_ccw) || (edge_fire && !clockwise);
    end

    assign hold_update       = s_fire && (prescale_cnt_reg == 8'd0);
    assign prescale_cnt_next = (prescale_cnt_reg == 8'd0) ? prescale_reload_reg
                                                         : prescale_cnt_reg - 8'd1;

    rebq_hold #(
        .HOLD_WIDTH(HOLD_WIDTH)
    ) u_hold (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .update           (hold_update),
        .pressed          (s_data.button_level),
        .thresh           (thresh_reg),
        .press_class_next (press_class_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_int_reg      <= '0;
            dt_int_reg       <= '0;
            last_qclk_reg    <= 1'b0;
            cw_flag_reg      <= 1'b0;
            ccw_flag_reg     <= 1'b0;
            prescale_cnt_reg <= '0;
        end else if (s_fire) begin
            clk_int_reg      <= clk_int_next;
            dt_int_reg       <= dt_int_next;
            last_qclk_reg    <= qclk;
            cw_flag_reg      <= cw_flag_next;
            ccw_flag_reg     <= ccw_flag_next;
            prescale_cnt_reg <= prescale_cnt_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg.cw_pending  <= cw_flag_next;
            m_data_reg.ccw_pending <= ccw_flag_next;
            m_data_reg.press_class <= press_class_next;
        end
    end

    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("no result after an accepted transaction");

    a_ack_clears_cw: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.ack_cw && !(edge_fire && clockwise)) |=> !m_data.cw_pending)
        else $error("acknowledged clockwise step still pending");

    a_prescale_countdown: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && prescale_cnt_reg != 8'd0) |=>
            prescale_cnt_reg == $past(prescale_cnt_reg) - 8'd1)
        else $error("prescaler did not count down");

    a_state_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> ($stable(clk_int_reg) && $stable(cw_flag_reg) && $stable(ccw_flag_reg)))
        else $error("filter state changed without a transaction");

endmodule

// ===== tb/sv/rotary_encoder_and_button_qualifier_tb.sv =====
// testbench: rotary encoder and button qualifier, predicted and checked per transaction
`timescale 1ns / 100ps

module rotary_encoder_and_button_qualifier_tb;

    localparam int HOLD_W = 16;

    typedef struct packed {
        rebq_pkg::in_t  tick;
        logic           typed;
        rebq_pkg::out_t want;
    } dir_row_t;

    localparam rebq_pkg::out_t NO_STEP = '{1'b0, 1'b0, rebq_pkg::CLASS_NONE};
    localparam rebq_pkg::out_t CW_STEP = '{1'b1, 1'b0, rebq_pkg::CLASS_NONE};

    // columns of tick: clk dt btn ack_cw ack_ccw, at reset settings
    localparam dir_row_t DIRECTED [25] = '{
        '{5'b00000, 1'b1, NO_STEP},  // first tick after reset, button updates
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b11100, 1'b1, CW_STEP},  // clock integrator crosses threshold, data high
        '{5'b11110, 1'b0, NO_STEP},  // ack clears the clockwise step
        '{5'b00100, 1'b0, NO_STEP},
        '{5'b00100, 1'b0, NO_STEP},
        '{5'b10101, 1'b0, NO_STEP},  // ack in the tick of a new ccw edge
        '{5'b10101, 1'b0, NO_STEP},
        '{5'b01100, 1'b0, NO_STEP},
        '{5'b01100, 1'b0, NO_STEP},
        '{5'b11110, 1'b0, NO_STEP},  // ack in the tick of a new cw edge
        '{5'b11111, 1'b0, NO_STEP},
        '{5'b00000, 1'b0, NO_STEP},
        '{5'b10000, 1'b0, NO_STEP},
        '{5'b11100, 1'b0, NO_STEP},  // pump both integrators up to the roof
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b11100, 1'b0, NO_STEP},
        '{5'b00011, 1'b0, NO_STEP}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    rebq_pkg::in_t        s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    rebq_pkg::out_t       m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    rebq_pkg::cfg_index_t cfg_addr = rebq_pkg::REG_DIRECTION_SWAP;
    logic [rebq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // side info carried with the offered transaction
    logic           cur_typed = 1'b0;
    rebq_pkg::out_t cur_want = '0;

    // register copies
    logic        pr_swap   = rebq_pkg::RST_DIRECTION_SWAP;
    logic [7:0]  pr_roof   = rebq_pkg::RST_FILTER_ROOF;
    logic [7:0]  pr_thr    = rebq_pkg::RST_FILTER_THRESHOLD;
    logic [7:0]  pr_reload = rebq_pkg::RST_PRESCALE_RELOAD;
    logic [15:0] pr_full   = rebq_pkg::RST_THRESH_FULL;
    logic [15:0] pr_half   = rebq_pkg::RST_THRESH_HALF;
    logic [15:0] pr_min    = rebq_pkg::RST_THRESH_MIN;

    // qualifier state
    logic [7:0]        st_clk_acc  = '0;
    logic [7:0]        st_dt_acc   = '0;
    logic              st_last_q   = 1'b0;
    logic              st_cw       = 1'b0;
    logic              st_ccw      = 1'b0;
    logic [7:0]        st_prescale = '0;
    logic [HOLD_W-1:0] st_hold     = '0;

    rebq_pkg::out_t pending_results [$];
    int             mismatches = 0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic rx_hold_off = 1'b0;

    // pin run generator
    logic clk_lvl = 1'b0, dt_lvl = 1'b0, btn_lvl = 1'b0;
    int   clk_run = 0, dt_run = 0, btn_run = 0;
    int   max_pin_run = 8;
    int   btn_max_run = 40;

    rotary_encoder_and_button_qualifier #(
        .HOLD_WIDTH(HOLD_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [7:0] filter_step(input logic [7:0] acc, input logic pin);
        if (pin) begin
            return (acc < pr_roof) ? acc + 8'd1 : acc;
        end
        return (acc == 8'd0) ? acc : acc - 8'd1;
    endfunction

    function automatic logic [HOLD_W-1:0] hold_step(input logic [HOLD_W-1:0] h,
                                                    input logic pressed);
        if (pressed) begin
            return (&h) ? h : h + 1'b1;
        end
        if (h > rebq_pkg::DECAY_BIG_ABOVE) return h - HOLD_W'(rebq_pkg::DECAY_BIG);
        if (h > rebq_pkg::DECAY_MID_ABOVE) return h - HOLD_W'(rebq_pkg::DECAY_MID);
        return (h == '0) ? h : h - 1'b1;
    endfunction

    // one sampling tick of the qualifier
    function automatic rebq_pkg::out_t encoder_tick(input rebq_pkg::in_t d);
        rebq_pkg::out_t r;
        logic qclk;
        if (d.ack_cw) st_cw = 1'b0;
        if (d.ack_ccw) st_ccw = 1'b0;
        st_clk_acc = filter_step(st_clk_acc, d.clk_level);
        st_dt_acc  = filter_step(st_dt_acc, d.dt_level);
        qclk = st_clk_acc > pr_thr;
        if (qclk && !st_last_q) begin
            if ((st_dt_acc > pr_thr) ^ pr_swap) st_cw = 1'b1;
            else st_ccw = 1'b1;
        end
        st_last_q = qclk;
        if (st_prescale == 8'd0) begin
            st_hold = hold_step(st_hold, d.button_level);
            st_prescale = pr_reload;
        end else begin
            st_prescale = st_prescale - 8'd1;
        end
        r.cw_pending  = st_cw;
        r.ccw_pending = st_ccw;
        if (st_hold > pr_full) r.press_class = rebq_pkg::CLASS_FULL;
        else if (st_hold > pr_half) r.press_class = rebq_pkg::CLASS_HALF;
        else if (st_hold > pr_min) r.press_class = rebq_pkg::CLASS_MIN;
        else r.press_class = rebq_pkg::CLASS_NONE;
        return r;
    endfunction

    // encoder-like pin levels held for random runs, with one-tick glitches
    function automatic rebq_pkg::in_t next_pins();
        rebq_pkg::in_t t;
        if (clk_run == 0) begin
            clk_lvl = ~clk_lvl;
            clk_run = $urandom_range(max_pin_run, 1);
        end
        if (dt_run == 0) begin
            dt_lvl = 1'($urandom_range(1, 0));
            dt_run = $urandom_range(2 * max_pin_run, 1);
        end
        if (btn_run == 0) begin
            btn_lvl = ~btn_lvl;
            btn_run = $urandom_range(btn_max_run, 1);
        end
        clk_run--;
        dt_run--;
        btn_run--;
        t.clk_level    = clk_lvl ^ ($urandom_range(99) < 6);
        t.dt_level     = dt_lvl ^ ($urandom_range(99) < 6);
        t.button_level = btn_lvl ^ ($urandom_range(99) < 4);
        t.ack_cw       = $urandom_range(99) < 30;
        t.ack_ccw      = $urandom_range(99) < 30;
        return t;
    endfunction

    always @(posedge aclk) begin
        m_ready <= !rx_hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : monitor
        rebq_pkg::out_t pred;
        rebq_pkg::out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    rebq_pkg::REG_DIRECTION_SWAP:   pr_swap   = cfg_data[0];
                    rebq_pkg::REG_FILTER_ROOF:      pr_roof   = cfg_data[7:0];
                    rebq_pkg::REG_FILTER_THRESHOLD: pr_thr    = cfg_data[7:0];
                    rebq_pkg::REG_PRESCALE_RELOAD:  pr_reload = cfg_data[7:0];
                    rebq_pkg::REG_THRESH_FULL:      pr_full   = cfg_data;
                    rebq_pkg::REG_THRESH_HALF:      pr_half   = cfg_data;
                    rebq_pkg::REG_THRESH_MIN:       pr_min    = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pred = encoder_tick(s_data);
                pending_results.push_back(cur_typed ? cur_want : pred);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.cw_pending !== want.cw_pending) begin
                        $display("%0t: cw_pending expected %0b actual %0b", $time,
                                 want.cw_pending, m_data.cw_pending);
                        mismatches++;
                    end
                    if (m_data.ccw_pending !== want.ccw_pending) begin
                        $display("%0t: ccw_pending expected %0b actual %0b", $time,
                                 want.ccw_pending, m_data.ccw_pending);
                        mismatches++;
                    end
                    if (m_data.press_class !== want.press_class) begin
                        $display("%0t: press_class expected %0d actual %0d", $time,
                                 want.press_class, m_data.press_class);
                        mismatches++;
                    end
                end
            end
        end
    end

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input rebq_pkg::cfg_index_t idx,
                             input logic [rebq_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic swap, input logic [7:0] roof,
                             input logic [7:0] thr, input logic [7:0] reload,
                             input logic [15:0] t_full, input logic [15:0] t_half,
                             input logic [15:0] t_min);
        write_reg(rebq_pkg::REG_DIRECTION_SWAP, {15'd0, swap});
        write_reg(rebq_pkg::REG_FILTER_ROOF, {8'd0, roof});
        write_reg(rebq_pkg::REG_FILTER_THRESHOLD, {8'd0, thr});
        write_reg(rebq_pkg::REG_PRESCALE_RELOAD, {8'd0, reload});
        write_reg(rebq_pkg::REG_THRESH_FULL, t_full);
        write_reg(rebq_pkg::REG_THRESH_HALF, t_half);
        write_reg(rebq_pkg::REG_THRESH_MIN, t_min);
        cfg_valid <= 1'b0;
    endtask

    // leaves s_valid high; finish_phase lowers it
    task automatic send_item(input rebq_pkg::in_t d, input logic typed,
                             input rebq_pkg::out_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= d;
        cur_typed <= typed;
        cur_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            send_item(next_pins(), 1'b0, NO_STEP);
        end
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        rebq_pkg::in_t t;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, directed ticks
        for (int r = 0; r < 25; r++) begin
            send_item(DIRECTED[r].tick, DIRECTED[r].typed, DIRECTED[r].want);
        end
        finish_phase();

        // swapped direction, widest filter, button updates every tick
        configure(1'b1, 8'd255, 8'd0, 8'd0, 16'd60, 16'd20, 16'd3);
        max_pin_run = 12;
        btn_max_run = 80;
        run_random(40);
        // drive both integrators far up before the roof drops
        for (int k = 0; k < 50; k++) begin
            send_item(rebq_pkg::in_t'(5'b11000), 1'b0, NO_STEP);
        end
        finish_phase();

        // roof below the integrators, thresholds out of order
        configure(1'b0, 8'd4, 8'd2, 8'd1, 16'hFFFF, 16'd0, 16'hFFFF);
        max_pin_run = 5;
        btn_max_run = 30;
        send_idle_pct = 45;
        run_random(50);
        finish_phase();

        // roof of one, slowest prescaler, all thresholds zero
        configure(1'b0, 8'd1, 8'd0, 8'd255, 16'd0, 16'd0, 16'd0);
        max_pin_run = 3;
        send_idle_pct = 0;
        recv_stall_pct = 45;
        run_random(50);
        finish_phase();

        // threshold above the roof, long receiver hold-off
        configure(1'b1, 8'd20, 8'd254, 8'd3, 16'd10, 16'd50, 16'd100);
        max_pin_run = 25;
        send_idle_pct = 22;
        recv_stall_pct = 22;
        fork
            begin
                rx_hold_off <= 1'b1;
                repeat (150) @(posedge aclk);
                rx_hold_off <= 1'b0;
            end
            run_random(50);
        join
        finish_phase();

        // threshold just under the roof
        configure(1'b0, 8'd10, 8'd9, 8'd0, 16'd200, 16'd40, 16'd0);
        max_pin_run = 14;
        btn_max_run = 120;
        run_random(50);
        finish_phase();

        // hold count climbs, then decays through all of its bands
        configure(1'b0, 8'd10, 8'd3, 8'd0, 16'd55, 16'd20, 16'd5);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        max_pin_run = 8;
        for (int k = 0; k < 60; k++) begin
            t = next_pins();
            t.button_level = 1'b1;
            send_item(t, 1'b0, NO_STEP);
        end
        for (int k = 0; k < 40; k++) begin
            t = next_pins();
            t.button_level = 1'b0;
            send_item(t, 1'b0, NO_STEP);
        end
        finish_phase();

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
